### rtl/dstat_pkg.sv
// Package for the duration statistics block: action codes, sequencer states,
// statistics bundle and arithmetic constants. No dependencies.
package dstat_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DIV_CNT_W = 5;
    localparam int unsigned SCALE_W   = 10;

    localparam logic [SCALE_W-1:0] US_PER_MS = 10'd1000;
    localparam logic [DATA_W-1:0]  ALL_ONES  = '1;

    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_START   = 2'd1,
        ACT_END     = 2'd2,
        ACT_RESTART = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_DIV  = 2'd2,
        S_OUT  = 2'd3
    } t_state;

    typedef struct packed {
        logic              open;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] shortest;
        logic [DATA_W-1:0] longest;
    } t_stats;

endpackage

### rtl/duration_statistics_top.sv
// Duration statistics top level: stream ports, sequencer, scaling multiply,
// output register. Depends on dstat_pkg, dstat_stats and dstat_div.
// From input beat to output tvalid: multiply and divider load, 32 divider
// steps, done flag, output load; an output stall holds back the output load.
// A new beat is taken only after the last one is loaded out; the 32-step divider sets the pace.
// Reset: synchronous active-low i_rst_n clears statistics and sequencer.
module duration_statistics_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // now_ms[31:0]
    input  logic [1:0]   s_axis_tuser,   // action[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // sample_count, min_duration,
                                         // max_duration, average_us, measuring
);

    dstat_pkg::t_state r_state;
    dstat_pkg::t_state n_state;
    dstat_pkg::t_stats stats;

    logic                         accept;
    logic                         div_start;
    logic                         div_busy;
    logic                         div_done;
    logic [dstat_pkg::DATA_W-1:0] quotient;
    logic [dstat_pkg::DATA_W-1:0] product;
    logic                         load_out;
    logic                         r_m_valid;
    logic [135:0]                 r_m_data;
    logic [dstat_pkg::DATA_W-1:0] avg;

    assign accept = s_axis_tvalid && s_axis_tready;

    dstat_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_apply  (accept),
        .i_action (s_axis_tuser),
        .i_now_ms (s_axis_tdata),
        .o_stats  (stats)
    );

    assign product = stats.sum
                   * {{(dstat_pkg::DATA_W-dstat_pkg::SCALE_W){1'b0}}, dstat_pkg::US_PER_MS};

    dstat_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (stats.count),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dstat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        load_out      = 1'b0;
        case (r_state)
            dstat_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = dstat_pkg::S_MUL;
                end
            end
            dstat_pkg::S_MUL: begin
                div_start = 1'b1;
                n_state   = dstat_pkg::S_DIV;
            end
            dstat_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = dstat_pkg::S_OUT;
                end
            end
            dstat_pkg::S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = dstat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dstat_pkg::S_IDLE;
            end
        endcase
    end

    assign avg = (stats.count == '0) ? '0 : quotient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_m_data <= {7'b0, stats.open, avg, stats.longest, stats.shortest, stats.count};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef ASSERT_OFF
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == dstat_pkg::S_IDLE |-> !div_busy)
        else $error("divider busy while sequencer idle");

    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == dstat_pkg::S_MUL)
        else $error("accepted beat did not start the multiply step");

    a_empty_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stats.count == '0 |-> (stats.shortest == dstat_pkg::ALL_ONES && stats.longest == '0))
        else $error("min or max set with no recorded interval");
`endif

endmodule

### rtl/dstat_stats.sv
// Interval state and running statistics, updated once per accepted beat.
// Depends on dstat_pkg.
module dstat_stats (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_apply,
    input  logic [1:0]                       i_action,
    input  logic [dstat_pkg::DATA_W-1:0]     i_now_ms,
    output dstat_pkg::t_stats                o_stats
);

    logic                         r_open;
    logic [dstat_pkg::DATA_W-1:0] r_start;
    logic [dstat_pkg::DATA_W-1:0] r_sum;
    logic [dstat_pkg::DATA_W-1:0] r_count;
    logic [dstat_pkg::DATA_W-1:0] r_shortest;
    logic [dstat_pkg::DATA_W-1:0] r_longest;

    logic                         n_open;
    logic [dstat_pkg::DATA_W-1:0] n_start;
    logic [dstat_pkg::DATA_W-1:0] n_sum;
    logic [dstat_pkg::DATA_W-1:0] n_count;
    logic [dstat_pkg::DATA_W-1:0] n_shortest;
    logic [dstat_pkg::DATA_W-1:0] n_longest;

    logic [dstat_pkg::DATA_W-1:0] dur;
    logic                         sat;
    logic                         rec;

    assign dur = i_now_ms - r_start;
    assign sat = (r_count == dstat_pkg::ALL_ONES);

    always_comb begin
        n_open     = r_open;
        n_start    = r_start;
        n_sum      = r_sum;
        n_count    = r_count;
        n_shortest = r_shortest;
        n_longest  = r_longest;
        rec        = 1'b0;
        case (dstat_pkg::t_action'(i_action))
            dstat_pkg::ACT_CLEAR: begin
                n_open     = 1'b0;
                n_start    = '0;
                n_sum      = '0;
                n_count    = '0;
                n_shortest = dstat_pkg::ALL_ONES;
                n_longest  = '0;
            end
            dstat_pkg::ACT_START: begin
                n_open  = 1'b1;
                n_start = i_now_ms;
            end
            dstat_pkg::ACT_END: begin
                if (!sat && r_open) begin
                    n_open = 1'b0;
                    rec    = 1'b1;
                end
            end
            dstat_pkg::ACT_RESTART: begin
                if (!sat) begin
                    rec     = r_open;
                    n_open  = 1'b1;
                    n_start = i_now_ms;
                end
            end
            default: begin
                n_open = r_open;
            end
        endcase
        if (rec) begin
            n_sum   = r_sum + dur;
            n_count = r_count + 1'b1;
            if (dur > r_longest) begin
                n_longest = dur;
            end
            if (dur < r_shortest) begin
                n_shortest = dur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_start    <= '0;
            r_sum      <= '0;
            r_count    <= '0;
            r_shortest <= dstat_pkg::ALL_ONES;
            r_longest  <= '0;
        end else if (i_apply) begin
            r_open     <= n_open;
            r_start    <= n_start;
            r_sum      <= n_sum;
            r_count    <= n_count;
            r_shortest <= n_shortest;
            r_longest  <= n_longest;
        end
    end

    assign o_stats = '{open: r_open, count: r_count, sum: r_sum,
                       shortest: r_shortest, longest: r_longest};

endmodule

### rtl/dstat_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 32 quotient bits per run.
// Depends on dstat_pkg.
module dstat_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dstat_pkg::DATA_W-1:0] i_dividend,
    input  logic [dstat_pkg::DATA_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [dstat_pkg::DATA_W-1:0] o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [dstat_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [dstat_pkg::DATA_W-1:0]    r_quo;
    logic [dstat_pkg::DATA_W-1:0]    r_rem;
    logic [dstat_pkg::DATA_W-1:0]    r_dsr;

    logic [dstat_pkg::DATA_W:0]      shifted;
    logic [dstat_pkg::DATA_W+1:0]    diff;
    logic                            ge;

    assign shifted = {r_rem, r_quo[dstat_pkg::DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dsr};
    assign ge      = !diff[dstat_pkg::DATA_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == dstat_pkg::DIV_CNT_W'(dstat_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[dstat_pkg::DATA_W-2:0], ge};
            r_rem <= ge ? diff[dstat_pkg::DATA_W-1:0] : shifted[dstat_pkg::DATA_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
